// ===== rtl/ilha_pkg.sv =====
`timescale 1ns / 1ps

package ilha_pkg;

    // Heap geometry defaults
    localparam int DEFAULT_HEAP_BYTES = 65536;
    localparam int WORD_BYTES         = 4;

    // Tag word: block size with the allocated flag in bit 0
    typedef logic [31:0] tag_t;

    localparam tag_t EPILOGUE_TAG = 32'd1;
    localparam tag_t DSIZE        = 32'd8;
    localparam tag_t MIN_BLOCK    = 2 * DSIZE;
    localparam tag_t TAG_MASK     = ~32'h7;
    localparam tag_t FIRST_HDR    = 32'd12;

    localparam logic [16:0] CHUNK_RESET = 17'(1 << 12);
    localparam logic [16:0] CHUNK_MIN   = 17'd8;

    // Operation codes
    localparam logic [1:0] OP_INIT    = 2'd0;
    localparam logic [1:0] OP_ALLOC   = 2'd1;
    localparam logic [1:0] OP_FREE    = 2'd2;
    localparam logic [1:0] OP_REALLOC = 2'd3;

    // Status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_NOSIZE = 2'd1;
    localparam logic [1:0] ST_OOM    = 2'd2;

    // Register indexes
    localparam logic REG_GROW_CHUNK = 1'b0;

endpackage

// ===== rtl/ilha_ram.sv =====
`timescale 1ns / 1ps

module ilha_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16384
) (
    input  logic                     clk,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic                     we,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write, or read through a registered output
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// ===== rtl/implicit_list_heap_allocator_unit.sv =====
`timescale 1ns / 1ps

// Boundary-tag heap allocator with an implicit block list and first-fit
// search. Each item (init, allocate, free, reallocate) returns one result
// item. All tags live in one single-port RAM of HEAP_BYTES/4 words with a
// registered read, and the sequencer makes at most one tag access per
// cycle. Init lays down the heap and grows it by the first chunk, and ends
// early when that chunk does not fit. Free checks the address first and ends
// there when the check fails. Allocate walks the headers, and grows the heap
// when no free block fits. Reallocate adds the address check and the freeing
// of the old block. The first-fit walk reads one tag per cycle and dominates
// on a fragmented heap. Only one item is worked on at a time; the next item is
// taken as soon as the result is parked in the output register.
// The tag RAM needs no clearing after reset: init writes all tags it uses.
module implicit_list_heap_allocator_unit
    import ilha_pkg::*;
#(
    parameter int HEAP_BYTES = DEFAULT_HEAP_BYTES
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  opcode,
    input  logic [15:0] block_address,
    input  logic [15:0] request_size,

    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] result_address,
    output logic [1:0]  status,
    output logic [15:0] copy_bytes,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int TAG_WORDS = HEAP_BYTES / WORD_BYTES;
    localparam int IW        = $clog2(TAG_WORDS);
    localparam int HW        = $clog2(HEAP_BYTES) + 1;
    localparam tag_t HEAP_W  = 32'(HEAP_BYTES);
    localparam tag_t WORDS_W = 32'(TAG_WORDS);

    // Sequencer states
    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_INIT0 = 5'd1;
    localparam logic [4:0] S_INIT1 = 5'd2;
    localparam logic [4:0] S_INIT2 = 5'd3;
    localparam logic [4:0] S_INIT3 = 5'd4;
    localparam logic [4:0] S_GROW  = 5'd5;
    localparam logic [4:0] S_GROW1 = 5'd6;
    localparam logic [4:0] S_GROW2 = 5'd7;
    localparam logic [4:0] S_MG0   = 5'd8;
    localparam logic [4:0] S_MG1   = 5'd9;
    localparam logic [4:0] S_MG2   = 5'd10;
    localparam logic [4:0] S_MG3   = 5'd11;
    localparam logic [4:0] S_MG4   = 5'd12;
    localparam logic [4:0] S_MGW1  = 5'd13;
    localparam logic [4:0] S_MGW2  = 5'd14;
    localparam logic [4:0] S_MGEND = 5'd15;
    localparam logic [4:0] S_AL0   = 5'd16;
    localparam logic [4:0] S_FF    = 5'd17;
    localparam logic [4:0] S_PL0   = 5'd18;
    localparam logic [4:0] S_PL1   = 5'd19;
    localparam logic [4:0] S_PLW1  = 5'd20;
    localparam logic [4:0] S_PLW2  = 5'd21;
    localparam logic [4:0] S_PLW3  = 5'd22;
    localparam logic [4:0] S_PLW4  = 5'd23;
    localparam logic [4:0] S_ALEND = 5'd24;
    localparam logic [4:0] S_VB0   = 5'd25;
    localparam logic [4:0] S_VB1   = 5'd26;
    localparam logic [4:0] S_RL0   = 5'd27;
    localparam logic [4:0] S_RL1   = 5'd28;
    localparam logic [4:0] S_RL2   = 5'd29;
    localparam logic [4:0] S_DONE  = 5'd30;

    // Who called the merge sequence
    localparam logic MK_GROW = 1'b0;
    localparam logic MK_REL  = 1'b1;

    // Control registers
    logic [4:0]    state_reg, state_next;
    logic [HW-1:0] heap_end_reg, heap_end_next;
    logic          ready_reg, ready_next;
    logic [16:0]   chunk_reg;
    logic          out_valid_reg, out_valid_next;
    logic          rd_oob_reg, rd_oob_next;

    // Item and working registers
    logic [1:0]  op_reg, op_next;
    logic [15:0] addr_reg, addr_next;
    logic [15:0] req_reg, req_next;
    tag_t        asize_reg, asize_next;
    tag_t        bytes_reg, bytes_next;
    tag_t        bp_reg, bp_next;
    tag_t        size_reg, size_next;
    tag_t        pword_reg, pword_next;
    tag_t        nword_reg, nword_next;
    tag_t        prev_reg, prev_next;
    tag_t        p_reg, p_next;
    tag_t        have_reg, have_next;
    tag_t        oldpay_reg, oldpay_next;
    tag_t        wa1_reg, wa1_next;
    tag_t        wd1_reg, wd1_next;
    tag_t        wa2_reg, wa2_next;
    tag_t        wd2_reg, wd2_next;
    logic        split_reg, split_next;
    logic        mk_reg, mk_next;
    logic        range_ok_reg, range_ok_next;
    logic        ok_reg, ok_next;
    logic        alloc_ok_reg, alloc_ok_next;
    logic [15:0] res_reg, res_next;
    logic [1:0]  status_reg, status_next;
    logic [15:0] copy_reg, copy_next;
    logic [15:0] out_res_reg, out_res_next;
    logic [1:0]  out_status_reg, out_status_next;
    logic [15:0] out_copy_reg, out_copy_next;

    // Tag RAM port
    tag_t          mem_off;
    logic          mem_we;
    tag_t          mem_wdata;
    tag_t          mem_idx;
    logic          mem_in_range;
    logic [IW-1:0] ram_addr;
    tag_t          ram_rdata;

    // Derived values
    tag_t rdata;
    tag_t rsize;
    logic ralloc;
    tag_t heap32;
    tag_t addr32;
    tag_t req32;
    tag_t chunk8;
    tag_t ext;
    tag_t grow_words;
    tag_t grow_s;
    tag_t blk;
    tag_t next_p;
    tag_t tot;
    logic cfg_wr;

    ilha_ram #(
        .WIDTH (32),
        .DEPTH (TAG_WORDS)
    ) u_tags (
        .clk   (clk),
        .addr  (ram_addr),
        .we    (mem_we && mem_in_range),
        .wdata (mem_wdata),
        .rdata (ram_rdata)
    );

    // Map a byte offset to a word; accesses past the heap are dropped
    assign mem_idx      = mem_off >> 2;
    assign mem_in_range = mem_idx < WORDS_W;
    assign ram_addr     = mem_idx[IW-1:0];
    assign rd_oob_next  = !mem_in_range;

    assign rdata  = rd_oob_reg ? '0 : ram_rdata;
    assign rsize  = rdata & TAG_MASK;
    assign ralloc = rdata[0];

    assign heap32 = 32'(heap_end_reg);
    assign addr32 = 32'(addr_reg);
    assign req32  = 32'(req_reg);
    assign chunk8 = (chunk_reg < CHUNK_MIN) ? 32'(CHUNK_MIN) : 32'(chunk_reg);
    assign ext    = (asize_reg > chunk8) ? asize_reg : chunk8;

    // Growth size: whole words, rounded up to an even count
    assign grow_words = (bytes_reg >> 2) + {31'd0, bytes_reg[2]};
    assign grow_s     = grow_words << 2;

    assign blk    = split_reg ? asize_reg : have_reg;
    assign next_p = p_reg + rsize;
    assign tot    = size_reg + rsize;

    assign in_stall = (state_reg != S_IDLE);

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        heap_end_next   = heap_end_reg;
        ready_next      = ready_reg;
        op_next         = op_reg;
        addr_next       = addr_reg;
        req_next        = req_reg;
        asize_next      = asize_reg;
        bytes_next      = bytes_reg;
        bp_next         = bp_reg;
        size_next       = size_reg;
        pword_next      = pword_reg;
        nword_next      = nword_reg;
        prev_next       = prev_reg;
        p_next          = p_reg;
        have_next       = have_reg;
        oldpay_next     = oldpay_reg;
        wa1_next        = wa1_reg;
        wd1_next        = wd1_reg;
        wa2_next        = wa2_reg;
        wd2_next        = wd2_reg;
        split_next      = split_reg;
        mk_next         = mk_reg;
        range_ok_next   = range_ok_reg;
        ok_next         = ok_reg;
        alloc_ok_next   = alloc_ok_reg;
        res_next        = res_reg;
        status_next     = status_reg;
        copy_next       = copy_reg;
        out_res_next    = out_res_reg;
        out_status_next = out_status_reg;
        out_copy_next   = out_copy_reg;
        out_valid_next  = out_valid_reg && out_stall;
        mem_off         = '0;
        mem_we          = 1'b0;
        mem_wdata       = '0;

        case (state_reg)
            // Take an item and dispatch on its opcode
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next     = opcode;
                    addr_next   = block_address;
                    req_next    = request_size;
                    res_next    = '0;
                    status_next = ST_OK;
                    copy_next   = '0;
                    ok_next     = 1'b0;
                    if (request_size <= 16'd8)
                    begin
                        asize_next = MIN_BLOCK;
                    end
                    else
                    begin
                        asize_next = (32'(request_size) + 32'd15) & TAG_MASK;
                    end
                    if (opcode == OP_INIT)
                    begin
                        state_next = S_INIT0;
                    end
                    else if (!ready_reg)
                    begin
                        status_next = (opcode == OP_FREE) ? ST_OK : ST_OOM;
                        state_next  = S_DONE;
                    end
                    else if (opcode == OP_ALLOC)
                    begin
                        state_next = S_AL0;
                    end
                    else if (opcode == OP_FREE)
                    begin
                        state_next = S_VB0;
                    end
                    else if (block_address == 16'd0)
                    begin
                        state_next = S_AL0;
                    end
                    else
                    begin
                        state_next = S_VB0;
                    end
                end
            end

            // Lay down pad, prologue and epilogue
            S_INIT0:
            begin
                mem_off       = 32'd0;
                mem_we        = 1'b1;
                mem_wdata     = '0;
                ready_next    = 1'b0;
                heap_end_next = HW'(16);
                state_next    = S_INIT1;
            end

            S_INIT1:
            begin
                mem_off    = 32'd4;
                mem_we     = 1'b1;
                mem_wdata  = DSIZE | 32'd1;
                state_next = S_INIT2;
            end

            S_INIT2:
            begin
                mem_off    = 32'd8;
                mem_we     = 1'b1;
                mem_wdata  = DSIZE | 32'd1;
                state_next = S_INIT3;
            end

            S_INIT3:
            begin
                mem_off    = FIRST_HDR;
                mem_we     = 1'b1;
                mem_wdata  = EPILOGUE_TAG;
                bytes_next = chunk8;
                state_next = S_GROW;
            end

            // Grow the heap: check room, write the new block header, footer and epilogue
            S_GROW:
            begin
                if (heap32 > HEAP_W || grow_s > HEAP_W - heap32)
                begin
                    if (op_reg == OP_INIT)
                    begin
                        status_next = ST_OOM;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        alloc_ok_next = 1'b0;
                        state_next    = S_ALEND;
                    end
                end
                else
                begin
                    mem_off    = heap32 - 32'd4;
                    mem_we     = 1'b1;
                    mem_wdata  = grow_s;
                    size_next  = grow_s;
                    bp_next    = heap32;
                    state_next = S_GROW1;
                end
            end

            S_GROW1:
            begin
                mem_off    = bp_reg + size_reg - 32'd8;
                mem_we     = 1'b1;
                mem_wdata  = size_reg;
                state_next = S_GROW2;
            end

            S_GROW2:
            begin
                mem_off       = bp_reg + size_reg - 32'd4;
                mem_we        = 1'b1;
                mem_wdata     = EPILOGUE_TAG;
                heap_end_next = heap_end_reg + size_reg[HW-1:0];
                mk_next       = MK_GROW;
                state_next    = S_MG0;
            end

            // Merge: read own header, previous footer, next header
            S_MG0:
            begin
                mem_off    = bp_reg - 32'd4;
                state_next = S_MG1;
            end

            S_MG1:
            begin
                size_next  = rsize;
                mem_off    = bp_reg - 32'd8;
                state_next = S_MG2;
            end

            S_MG2:
            begin
                pword_next = rdata;
                mem_off    = bp_reg + size_reg - 32'd4;
                state_next = S_MG3;
            end

            S_MG3:
            begin
                nword_next = rdata;
                if (pword_reg[0] && ralloc)
                begin
                    state_next = S_MGEND;
                end
                else if (pword_reg[0])
                begin
                    wa1_next   = bp_reg - 32'd4;
                    wd1_next   = tot;
                    wa2_next   = bp_reg + tot - 32'd8;
                    wd2_next   = tot;
                    state_next = S_MGW1;
                end
                else
                begin
                    prev_next  = bp_reg - (pword_reg & TAG_MASK);
                    mem_off    = bp_reg - (pword_reg & TAG_MASK) - 32'd4;
                    state_next = S_MG4;
                end
            end

            // Previous block is free: merge into it
            S_MG4:
            begin
                if (nword_reg[0])
                begin
                    wa1_next = bp_reg + size_reg - 32'd8;
                    wd1_next = tot;
                    wa2_next = prev_reg - 32'd4;
                    wd2_next = tot;
                end
                else
                begin
                    wa1_next = prev_reg - 32'd4;
                    wd1_next = tot + (nword_reg & TAG_MASK);
                    wa2_next = bp_reg + size_reg + (nword_reg & TAG_MASK) - 32'd8;
                    wd2_next = tot + (nword_reg & TAG_MASK);
                end
                bp_next    = prev_reg;
                state_next = S_MGW1;
            end

            S_MGW1:
            begin
                mem_off    = wa1_reg;
                mem_we     = 1'b1;
                mem_wdata  = wd1_reg;
                state_next = S_MGW2;
            end

            S_MGW2:
            begin
                mem_off    = wa2_reg;
                mem_we     = 1'b1;
                mem_wdata  = wd2_reg;
                state_next = S_MGEND;
            end

            // Return from merge to its caller
            S_MGEND:
            begin
                if (mk_reg == MK_REL)
                begin
                    state_next = S_DONE;
                end
                else if (op_reg == OP_INIT)
                begin
                    ready_next = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_PL0;
                end
            end

            // Allocate: start the first-fit walk
            S_AL0:
            begin
                if (req_reg == 16'd0)
                begin
                    status_next = ST_NOSIZE;
                    state_next  = S_DONE;
                end
                else if (FIRST_HDR < heap32)
                begin
                    p_next     = FIRST_HDR;
                    mem_off    = FIRST_HDR;
                    state_next = S_FF;
                end
                else
                begin
                    bytes_next = ext;
                    state_next = S_GROW;
                end
            end

            // Walk: one header per cycle
            S_FF:
            begin
                if (rsize == '0)
                begin
                    bytes_next = ext;
                    state_next = S_GROW;
                end
                else if (!ralloc && rsize >= asize_reg)
                begin
                    bp_next    = p_reg + 32'd4;
                    state_next = S_PL0;
                end
                else if (rsize > heap32 - p_reg || next_p >= heap32)
                begin
                    bytes_next = ext;
                    state_next = S_GROW;
                end
                else
                begin
                    p_next  = next_p;
                    mem_off = next_p;
                end
            end

            // Place: mark allocated, split off the rest if it is large enough
            S_PL0:
            begin
                mem_off    = bp_reg - 32'd4;
                state_next = S_PL1;
            end

            S_PL1:
            begin
                have_next  = rsize;
                split_next = !(rsize < asize_reg || rsize - asize_reg < DSIZE);
                state_next = S_PLW1;
            end

            S_PLW1:
            begin
                mem_off    = bp_reg - 32'd4;
                mem_we     = 1'b1;
                mem_wdata  = blk | 32'd1;
                state_next = S_PLW2;
            end

            S_PLW2:
            begin
                mem_off   = bp_reg + blk - 32'd8;
                mem_we    = 1'b1;
                mem_wdata = blk | 32'd1;
                if (split_reg)
                begin
                    state_next = S_PLW3;
                end
                else
                begin
                    alloc_ok_next = 1'b1;
                    state_next    = S_ALEND;
                end
            end

            S_PLW3:
            begin
                mem_off    = bp_reg + asize_reg - 32'd4;
                mem_we     = 1'b1;
                mem_wdata  = have_reg - asize_reg;
                state_next = S_PLW4;
            end

            S_PLW4:
            begin
                mem_off       = bp_reg + have_reg - 32'd8;
                mem_we        = 1'b1;
                mem_wdata     = have_reg - asize_reg;
                alloc_ok_next = 1'b1;
                state_next    = S_ALEND;
            end

            // Allocate result; reallocate goes on to free the old block
            S_ALEND:
            begin
                if (alloc_ok_reg)
                begin
                    res_next    = bp_reg[15:0];
                    status_next = ST_OK;
                    if (op_reg == OP_REALLOC && ok_reg)
                    begin
                        copy_next  = (req32 < oldpay_reg) ? req_reg : oldpay_reg[15:0];
                        state_next = S_RL0;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
                else
                begin
                    res_next    = '0;
                    status_next = ST_OOM;
                    state_next  = S_DONE;
                end
            end

            // Check the address given for free or reallocate
            S_VB0:
            begin
                mem_off       = addr32 - 32'd4;
                range_ok_next = (addr32 >= MIN_BLOCK) && (addr_reg[2:0] == 3'd0)
                                && (addr32 < heap32);
                state_next    = S_VB1;
            end

            S_VB1:
            begin
                ok_next     = range_ok_reg && ralloc && rsize >= MIN_BLOCK
                              && rsize <= heap32 - addr32;
                oldpay_next = rsize - DSIZE;
                if (op_reg == OP_FREE || req_reg == 16'd0)
                begin
                    if (op_reg == OP_REALLOC)
                    begin
                        status_next = ST_NOSIZE;
                    end
                    if (range_ok_reg && ralloc && rsize >= MIN_BLOCK
                        && rsize <= heap32 - addr32)
                    begin
                        state_next = S_RL0;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
                else
                begin
                    state_next = S_AL0;
                end
            end

            // Release: clear the allocated flag, then merge
            S_RL0:
            begin
                mem_off    = addr32 - 32'd4;
                state_next = S_RL1;
            end

            S_RL1:
            begin
                size_next  = rsize;
                mem_off    = addr32 - 32'd4;
                mem_we     = 1'b1;
                mem_wdata  = rsize;
                state_next = S_RL2;
            end

            S_RL2:
            begin
                mem_off    = addr32 + size_reg - 32'd8;
                mem_we     = 1'b1;
                mem_wdata  = size_reg;
                bp_next    = addr32;
                mk_next    = MK_REL;
                state_next = S_MG0;
            end

            // Hand the result to the output register
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_res_next    = res_reg;
                    out_status_next = status_reg;
                    out_copy_next   = copy_reg;
                    out_valid_next  = 1'b1;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            heap_end_reg  <= '0;
            ready_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            chunk_reg     <= CHUNK_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            heap_end_reg  <= heap_end_next;
            ready_reg     <= ready_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr)
            begin
                chunk_reg <= pwdata[16:0];
            end
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        rd_oob_reg     <= rd_oob_next;
        op_reg         <= op_next;
        addr_reg       <= addr_next;
        req_reg        <= req_next;
        asize_reg      <= asize_next;
        bytes_reg      <= bytes_next;
        bp_reg         <= bp_next;
        size_reg       <= size_next;
        pword_reg      <= pword_next;
        nword_reg      <= nword_next;
        prev_reg       <= prev_next;
        p_reg          <= p_next;
        have_reg       <= have_next;
        oldpay_reg     <= oldpay_next;
        wa1_reg        <= wa1_next;
        wd1_reg        <= wd1_next;
        wa2_reg        <= wa2_next;
        wd2_reg        <= wd2_next;
        split_reg      <= split_next;
        mk_reg         <= mk_next;
        range_ok_reg   <= range_ok_next;
        ok_reg         <= ok_next;
        alloc_ok_reg   <= alloc_ok_next;
        res_reg        <= res_next;
        status_reg     <= status_next;
        copy_reg       <= copy_next;
        out_res_reg    <= out_res_next;
        out_status_reg <= out_status_next;
        out_copy_reg   <= out_copy_next;
    end

    // Configuration port
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_GROW_CHUNK);
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_GROW_CHUNK) ? 32'(chunk_reg) : '0;

    assign out_valid      = out_valid_reg;
    assign result_address = out_res_reg;
    assign status         = out_status_reg;
    assign copy_bytes     = out_copy_reg;

endmodule
